// ----- design/lra_pkg.sv -----
package lra_pkg;

   localparam int TABLE_ENTRIES_DEF = 8;
   localparam int MAX_REMOVALS = 8;
   localparam int RM_W = $clog2(MAX_REMOVALS + 1);
   localparam logic [63:0] EXPIRY_RESET = 64'd1000000;

   localparam int REQ_DATA_W = 104;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 136;
   localparam int RSP_USER_W = 4;

   typedef enum logic [1:0] {
      OP_ANNOUNCE  = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_SWEEP     = 2'd2,
      OP_QUERY     = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      EV_APPEARED    = 3'd0,
      EV_RESTARTED   = 3'd1,
      EV_DISAPPEARED = 3'd2,
      EV_QUERY       = 3'd3,
      EV_FULL        = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_FLUSH
   } state_type;

endpackage

// ----- design/liveness_registry_with_aging.sv -----
// Presence table of up to TABLE_ENTRIES sources keyed by kind and route, kept in arrival
// order. Announces and serial heartbeats refresh or append an entry, sweeps drop aged
// entries (at most eight per sweep) and queries return the first nonzero node id for a
// kind. The table is walked one entry per cycle, save while a sweep waits on the result side,
// past a single compare and age unit at its head, each entry being reinserted at the tail
// of the live region or dropped; a new item is taken only once the last is through, and a
// rejected announce gives no word. The user must write expiry_time_us through csr_wr_en and
// csr_wr_data only while the block is idle; the block itself does not enforce this.
module liveness_registry_with_aging
   import lra_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [63:0]           csr_wr_data,     // expiry_time_us
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // source_kind[7:0], node_ident[39:8], now_us[103:40]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0], packet_ok[2]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_kind[7:0], out_node_ident[39:8], out_last_seen_us[103:40], reject_total[135:104]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // event_code[2:0], out_via_serial[3]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // table storage, read only at the head
   logic [7:0]  kind_ff  [TABLE_ENTRIES];
   logic [7:0]  kind_in  [TABLE_ENTRIES];
   logic        route_ff [TABLE_ENTRIES];
   logic        route_in [TABLE_ENTRIES];
   logic [31:0] node_ff  [TABLE_ENTRIES];
   logic [31:0] node_in  [TABLE_ENTRIES];
   logic [63:0] seen_ff  [TABLE_ENTRIES];
   logic [63:0] seen_in  [TABLE_ENTRIES];

   state_type        state_ff, state_in;
   opcode_type       op_ff, op_in;
   logic [7:0]       kind_arg_ff, kind_arg_in;
   logic [31:0]      node_arg_ff, node_arg_in;
   logic             route_arg_ff, route_arg_in;
   logic [63:0]      now_ff, now_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [RM_W-1:0]  removed_ff, removed_in;
   logic             hit_ff, hit_in;
   logic             restart_ff, restart_in;
   logic [31:0]      reject_ff, reject_in;
   logic [63:0]      expiry_ff, expiry_in;

   logic             pend_valid_ff, pend_valid_in;
   event_type        pend_code_ff, pend_code_in;
   logic [7:0]       pend_kind_ff, pend_kind_in;
   logic [31:0]      pend_node_ff, pend_node_in;
   logic             pend_serial_ff, pend_serial_in;
   logic [63:0]      pend_seen_ff, pend_seen_in;

   logic             rsp_valid_ff, rsp_valid_in;
   event_type        rsp_code_ff, rsp_code_in;
   logic [7:0]       rsp_kind_ff, rsp_kind_in;
   logic [31:0]      rsp_node_ff, rsp_node_in;
   logic             rsp_serial_ff, rsp_serial_in;
   logic [63:0]      rsp_seen_ff, rsp_seen_in;
   logic [31:0]      rsp_reject_ff, rsp_reject_in;
   logic             rsp_last_ff, rsp_last_in;

   opcode_type       req_op;
   logic [7:0]       req_kind;
   logic [31:0]      req_node;
   logic [63:0]      req_now;
   logic             req_ok;

   logic             shift_en, wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       wr_kind;
   logic             wr_route;
   logic [31:0]      wr_node;
   logic [63:0]      wr_seen;
   logic             out_load, out_last, out_free;
   logic [CNT_W-1:0] cnt_m1;
   logic [64:0]      age_diff;
   logic             aged, key_match;

   assign req_op   = opcode_type'(req_tuser[1:0]);
   assign req_ok   = req_tuser[2];
   assign req_kind = req_tdata[7:0];
   assign req_node = req_tdata[39:8];
   assign req_now  = req_tdata[103:40];

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_reject_ff, rsp_seen_ff, rsp_node_ff, rsp_kind_ff};
   assign rsp_tuser  = {rsp_serial_ff, rsp_code_ff};
   assign rsp_tlast  = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_m1   = cnt_ff - CNT_W'(1);

   // shared head unit: key compare and age check
   assign key_match = (kind_ff[0] == kind_arg_ff) && (route_ff[0] == route_arg_ff);
   assign age_diff  = {1'b0, now_ff} - {1'b0, seen_ff[0]};
   assign aged      = !age_diff[64] && (age_diff[63:0] >= expiry_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      kind_arg_in    = kind_arg_ff;
      node_arg_in    = node_arg_ff;
      route_arg_in   = route_arg_ff;
      now_in         = now_ff;
      cnt_in         = cnt_ff;
      left_in        = left_ff;
      removed_in     = removed_ff;
      hit_in         = hit_ff;
      restart_in     = restart_ff;
      reject_in      = reject_ff;
      expiry_in      = csr_wr_en ? csr_wr_data : expiry_ff;
      pend_valid_in  = pend_valid_ff;
      pend_code_in   = pend_code_ff;
      pend_kind_in   = pend_kind_ff;
      pend_node_in   = pend_node_ff;
      pend_serial_in = pend_serial_ff;
      pend_seen_in   = pend_seen_ff;
      shift_en       = 1'b0;
      wr_en          = 1'b0;
      wr_idx         = cnt_m1[IDX_W-1:0];
      wr_kind        = kind_ff[0];
      wr_route       = route_ff[0];
      wr_node        = node_ff[0];
      wr_seen        = seen_ff[0];
      out_load       = 1'b0;
      out_last       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == OP_ANNOUNCE && (req_node == 32'd0 || !req_ok)) begin
                  if (reject_ff != '1) begin
                     reject_in = reject_ff + 32'd1;
                  end
               end else begin
                  op_in        = req_op;
                  kind_arg_in  = (req_op == OP_HEARTBEAT) ? 8'd0 : req_kind;
                  node_arg_in  = (req_op == OP_HEARTBEAT) ? 32'd0 : req_node;
                  route_arg_in = (req_op == OP_HEARTBEAT);
                  now_in       = req_now;
                  left_in      = cnt_ff;
                  removed_in   = '0;
                  hit_in       = 1'b0;
                  restart_in   = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (left_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               left_in = left_ff - CNT_W'(1);
               unique case (op_ff) inside
                  OP_ANNOUNCE, OP_HEARTBEAT: begin
                     shift_en = 1'b1;
                     wr_en    = 1'b1;
                     if (key_match && !hit_ff) begin
                        hit_in     = 1'b1;
                        restart_in = (node_arg_ff != 32'd0) && (node_ff[0] != node_arg_ff);
                        wr_node    = node_arg_ff;
                        wr_seen    = now_ff;
                     end
                  end
                  OP_QUERY: begin
                     shift_en = 1'b1;
                     wr_en    = 1'b1;
                     if (!hit_ff && kind_ff[0] == kind_arg_ff && node_ff[0] != 32'd0) begin
                        hit_in         = 1'b1;
                        pend_node_in   = node_ff[0];
                        pend_serial_in = route_ff[0];
                        pend_seen_in   = seen_ff[0];
                     end
                  end
                  OP_SWEEP: begin
                     if (aged && removed_ff < RM_W'(MAX_REMOVALS)) begin
                        if (pend_valid_ff && !out_free) begin
                           // hold the walk until the earlier word can move out
                           left_in = left_ff;
                        end else begin
                           out_load       = pend_valid_ff;
                           pend_valid_in  = 1'b1;
                           pend_code_in   = EV_DISAPPEARED;
                           pend_kind_in   = kind_ff[0];
                           pend_node_in   = node_ff[0];
                           pend_serial_in = route_ff[0];
                           pend_seen_in   = seen_ff[0];
                           shift_en       = 1'b1;
                           cnt_in         = cnt_m1;
                           removed_in     = removed_ff + RM_W'(1);
                        end
                     end else begin
                        shift_en = 1'b1;
                        wr_en    = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FINISH: begin
            state_in = ST_FLUSH;
            unique case (op_ff) inside
               OP_ANNOUNCE, OP_HEARTBEAT: begin
                  pend_kind_in   = kind_arg_ff;
                  pend_node_in   = node_arg_ff;
                  pend_serial_in = route_arg_ff;
                  pend_seen_in   = now_ff;
                  if (hit_ff) begin
                     pend_valid_in = restart_ff;
                     pend_code_in  = EV_RESTARTED;
                  end else if (cnt_ff < CNT_W'(TABLE_ENTRIES)) begin
                     wr_en         = 1'b1;
                     wr_idx        = cnt_ff[IDX_W-1:0];
                     wr_kind       = kind_arg_ff;
                     wr_route      = route_arg_ff;
                     wr_node       = node_arg_ff;
                     wr_seen       = now_ff;
                     cnt_in        = cnt_ff + CNT_W'(1);
                     pend_valid_in = 1'b1;
                     pend_code_in  = EV_APPEARED;
                  end else begin
                     pend_valid_in = 1'b1;
                     pend_code_in  = EV_FULL;
                  end
               end
               OP_QUERY: begin
                  pend_valid_in = 1'b1;
                  pend_code_in  = EV_QUERY;
                  pend_kind_in  = kind_arg_ff;
                  if (!hit_ff) begin
                     pend_node_in   = 32'd0;
                     pend_serial_in = 1'b0;
                     pend_seen_in   = 64'd0;
                  end
               end
               OP_SWEEP: ;
               default: ;
            endcase
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // table update: pop the head, then place one word at the chosen slot
   always_comb begin
      kind_in  = kind_ff;
      route_in = route_ff;
      node_in  = node_ff;
      seen_in  = seen_ff;
      if (shift_en) begin
         for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
            kind_in[i]  = kind_ff[i+1];
            route_in[i] = route_ff[i+1];
            node_in[i]  = node_ff[i+1];
            seen_in[i]  = seen_ff[i+1];
         end
      end
      if (wr_en) begin
         kind_in[wr_idx]  = wr_kind;
         route_in[wr_idx] = wr_route;
         node_in[wr_idx]  = wr_node;
         seen_in[wr_idx]  = wr_seen;
      end
   end

   always_comb begin
      rsp_valid_in  = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_code_in   = rsp_code_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_serial_in = rsp_serial_ff;
      rsp_seen_in   = rsp_seen_ff;
      rsp_reject_in = rsp_reject_ff;
      rsp_last_in   = rsp_last_ff;
      if (out_load) begin
         rsp_code_in   = pend_code_ff;
         rsp_kind_in   = pend_kind_ff;
         rsp_node_in   = pend_node_ff;
         rsp_serial_in = pend_serial_ff;
         rsp_seen_in   = pend_seen_ff;
         rsp_reject_in = reject_ff;
         rsp_last_in   = out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         reject_ff     <= '0;
         expiry_ff     <= EXPIRY_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         reject_ff     <= reject_in;
         expiry_ff     <= expiry_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      route_ff       <= route_in;
      node_ff        <= node_in;
      seen_ff        <= seen_in;
      op_ff          <= op_in;
      kind_arg_ff    <= kind_arg_in;
      node_arg_ff    <= node_arg_in;
      route_arg_ff   <= route_arg_in;
      now_ff         <= now_in;
      left_ff        <= left_in;
      removed_ff     <= removed_in;
      hit_ff         <= hit_in;
      restart_ff     <= restart_in;
      pend_code_ff   <= pend_code_in;
      pend_kind_ff   <= pend_kind_in;
      pend_node_ff   <= pend_node_in;
      pend_serial_ff <= pend_serial_in;
      pend_seen_ff   <= pend_seen_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_serial_ff  <= rsp_serial_in;
      rsp_seen_ff    <= rsp_seen_in;
      rsp_reject_ff  <= rsp_reject_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

// ----- verif/testbench.sv -----
module testbench;
   import lra_pkg::*;

   localparam int SLOTS = TABLE_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      event_type   code;
      logic [7:0]  kind;
      logic [31:0] node;
      logic        serial;
      logic [63:0] seen;
      logic [31:0] rejects;
      logic        last;
   } presence_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [63:0]           csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // source_kind, node_ident, now_us
   logic [REQ_USER_W-1:0] req_tuser = '0;   // opcode, packet_ok
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // out_kind, out_node_ident, out_last_seen_us,
                                            // reject_total
   logic [RSP_USER_W-1:0] rsp_tuser;        // event_code, out_via_serial
   logic                  rsp_tlast;

   // predicted registry contents
   logic        registry_live  [SLOTS];
   logic [7:0]  registry_kind  [SLOTS];
   logic        registry_route [SLOTS];
   logic [31:0] registry_node  [SLOTS];
   logic [63:0] registry_stamp [SLOTS];
   logic [63:0] expiry_us = EXPIRY_RESET;
   logic [31:0] reject_count = '0;

   presence_word_type pending_words[$];
   presence_word_type item_words[MAX_REMOVALS];
   int                item_word_count;
   presence_word_type head_word;

   int          errors = 0;
   int          cycles = 0;
   logic        steady = 1'b0;
   logic [63:0] sim_us = '0;

   always #2 clock = ~clock;

   liveness_registry_with_aging i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   task automatic add_word(event_type code, logic [7:0] kind, logic [31:0] node,
                           logic serial, logic [63:0] seen);
      item_words[item_word_count] = '{code, kind, node, serial, seen, 32'd0, 1'b0};
      item_word_count++;
   endtask

   task automatic refresh_or_add(logic [7:0] kind, logic [31:0] node, logic serial,
                                 logic [63:0] now);
      int free_slot;
      logic restarted;
      free_slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!registry_live[i]) begin
            if (free_slot < 0) free_slot = i;
         end else if (registry_kind[i] == kind && registry_route[i] == serial) begin
            restarted = node != 0 && registry_node[i] != node;
            registry_node[i] = node;
            registry_stamp[i] = now;
            if (restarted) add_word(EV_RESTARTED, kind, node, serial, now);
            return;
         end
      end
      if (free_slot < 0) begin
         add_word(EV_FULL, kind, node, serial, now);
      end else begin
         registry_live[free_slot] = 1'b1;
         registry_kind[free_slot] = kind;
         registry_route[free_slot] = serial;
         registry_node[free_slot] = node;
         registry_stamp[free_slot] = now;
         add_word(EV_APPEARED, kind, node, serial, now);
      end
   endtask

   // later entries close up so the live ones stay packed from slot 0
   task automatic drop_slot(int s);
      for (int i = s; i + 1 < SLOTS; i++) begin
         registry_live[i] = registry_live[i + 1];
         registry_kind[i] = registry_kind[i + 1];
         registry_route[i] = registry_route[i + 1];
         registry_node[i] = registry_node[i + 1];
         registry_stamp[i] = registry_stamp[i + 1];
      end
      registry_live[SLOTS - 1] = 1'b0;
   endtask

   task automatic sweep_aged(logic [63:0] now);
      int i;
      i = 0;
      while (i < SLOTS && item_word_count < MAX_REMOVALS) begin
         if (registry_live[i] && now >= registry_stamp[i] &&
             now - registry_stamp[i] >= expiry_us) begin
            add_word(EV_DISAPPEARED, registry_kind[i], registry_node[i], registry_route[i],
                     registry_stamp[i]);
            drop_slot(i);
         end else begin
            i++;
         end
      end
   endtask

   task automatic answer_query(logic [7:0] kind);
      for (int i = 0; i < SLOTS; i++) begin
         if (registry_live[i] && registry_kind[i] == kind && registry_node[i] != 0) begin
            add_word(EV_QUERY, kind, registry_node[i], registry_route[i], registry_stamp[i]);
            return;
         end
      end
      add_word(EV_QUERY, kind, 32'd0, 1'b0, 64'd0);
   endtask

   task automatic predict_presence(opcode_type op, logic [7:0] kind, logic [31:0] node,
                                   logic ok, logic [63:0] now);
      item_word_count = 0;
      case (op)
         OP_ANNOUNCE: begin
            if (node == 0 || !ok) begin
               if (reject_count != 32'hFFFF_FFFF) reject_count++;
            end else begin
               refresh_or_add(kind, node, 1'b0, now);
            end
         end
         OP_HEARTBEAT: refresh_or_add(8'd0, 32'd0, 1'b1, now);
         OP_SWEEP:     sweep_aged(now);
         default:      answer_query(kind);
      endcase
      for (int k = 0; k < item_word_count; k++) begin
         item_words[k].rejects = reject_count;
         item_words[k].last = (k == item_word_count - 1);
         pending_words.insert(pending_words.size(), item_words[k]);
      end
   endtask

   // ---------------- result checking ----------------

   task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h got %h", $time, what, want, got);
         errors++;
      end
   endtask

   // sampled mid-cycle; the word is taken at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word expected none got %h %h %b", $time, rsp_tuser,
                     rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            head_word = pending_words.pop_front();
            check_field("event_code", 64'(head_word.code), 64'(rsp_tuser[2:0]));
            check_field("out_via_serial", 64'(head_word.serial), 64'(rsp_tuser[3]));
            check_field("out_kind", 64'(head_word.kind), 64'(rsp_tdata[7:0]));
            check_field("out_node_ident", 64'(head_word.node), 64'(rsp_tdata[39:8]));
            check_field("out_last_seen_us", head_word.seen, rsp_tdata[103:40]);
            check_field("reject_total", 64'(head_word.rejects), 64'(rsp_tdata[135:104]));
            check_field("last_of_run", 64'(head_word.last), 64'(rsp_tlast));
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic send_item(opcode_type op, logic [7:0] kind, logic [31:0] node, logic ok,
                            logic [63:0] now);
      if (!steady && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {now, node, kind};
      req_tuser <= {ok, op};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      predict_presence(op, kind, node, ok, now);
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      // an item with no word may still be walking the table
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_expiry(logic [63:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      expiry_us = value;
   endtask

   task automatic test_empty_and_rejects;
      send_item(OP_QUERY, 8'h00, 32'h0, 1'b1, 64'd0);
      send_item(OP_ANNOUNCE, 8'h12, 32'h0, 1'b1, 64'd3);
      send_item(OP_ANNOUNCE, 8'h12, 32'h1234_5678, 1'b0, 64'd4);
   endtask

   task automatic test_refresh_and_restart;
      send_item(OP_ANNOUNCE, 8'hFF, 32'hFFFF_FFFF, 1'b1, 64'd0);
      send_item(OP_HEARTBEAT, 8'h5A, 32'hDEAD_BEEF, 1'b0, 64'd5);
      send_item(OP_HEARTBEAT, 8'hA5, 32'h0, 1'b1, 64'd10);
      send_item(OP_ANNOUNCE, 8'hFF, 32'hFFFF_FFFF, 1'b1, 64'd15);
      send_item(OP_ANNOUNCE, 8'hFF, 32'h0000_0001, 1'b1, 64'd20);
      send_item(OP_QUERY, 8'hFF, 32'h0, 1'b0, 64'd21);
      // the heartbeat entry has kind 0 but node id zero, so no answer
      send_item(OP_QUERY, 8'h00, 32'h0, 1'b0, 64'd22);
   endtask

   task automatic test_table_full;
      for (int k = 1; k <= 6; k++)
         send_item(OP_ANNOUNCE, k[7:0], 32'h8000_0000 | k, 1'b1, 64'hFFFF_FFFF_FFFF_FF00);
      send_item(OP_ANNOUNCE, 8'h07, 32'h7777_7777, 1'b1, 64'hFFFF_FFFF_FFFF_FF00);
   endtask

   task automatic test_sweep_aging;
      // stamps far in the future are not aged
      send_item(OP_SWEEP, 8'h00, 32'h0, 1'b1, 64'd2_000_000);
      send_item(OP_SWEEP, 8'h00, 32'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_expiry_extremes;
      set_expiry(64'd0);
      send_item(OP_SWEEP, 8'h00, 32'h0, 1'b0, 64'hFFFF_FFFF_FFFF_FF00);
      set_expiry(64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_ANNOUNCE, 8'h55, 32'h5555_5555, 1'b1, 64'd0);
      send_item(OP_ANNOUNCE, 8'hAA, 32'hAAAA_AAAA, 1'b1, 64'd1);
      send_item(OP_SWEEP, 8'h00, 32'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic test_random_traffic(int count, logic [63:0] expiry, int step_max,
                                      logic quiet);
      int          r;
      opcode_type  op;
      logic [7:0]  kind;
      logic [31:0] node;
      logic        ok;
      logic [63:0] now;
      set_expiry(expiry);
      steady = quiet;
      sim_us = {$urandom, $urandom} >> $urandom_range(1, 40);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45) op = OP_ANNOUNCE;
         else if (r < 55) op = OP_HEARTBEAT;
         else if (r < 72) op = OP_SWEEP;
         else op = OP_QUERY;
         kind = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 9)) : 8'($urandom);
         r = $urandom_range(0, 99);
         if (r < 5) node = 32'h0;
         else if (r < 65) node = $urandom_range(1, 3);
         else node = $urandom;
         ok = $urandom_range(0, 99) >= 5;
         sim_us += 64'($urandom_range(0, step_max));
         now = ($urandom_range(0, 99) < 5) ? {$urandom, $urandom} : sim_us;
         send_item(op, kind, node, ok, now);
         if ($urandom_range(0, 99) < 2) drain();
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) registry_live[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_rejects();
      test_refresh_and_restart();
      test_table_full();
      test_sweep_aging();
      test_expiry_extremes();
      test_random_traffic(120, 64'd300, 100, 1'b0);
      test_random_traffic(80, 64'd0, 50, 1'b0);
      test_random_traffic(80, {$urandom, $urandom}, 1000, 1'b0);
      test_random_traffic(120, EXPIRY_RESET, 200000, 1'b1);
      test_random_traffic(60, 64'hFFFF_FFFF_FFFF_FFFF, 100, 1'b0);
      drain();
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
